FILE: sv/byte_ring_fifo_block_put_get_defines.svh
// assertion macros for the byte ring fifo
`ifndef BYTE_RING_FIFO_BLOCK_PUT_GET_DEFINES_SVH
`define BYTE_RING_FIFO_BLOCK_PUT_GET_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brf_pkg.sv
// shared constants and codes for the byte ring fifo
package brf_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int MAX_GET_DEF = 64;

    localparam logic [3:0] SIZE_LOG2_RST = 4'd8;

    // operation codes of an input word
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;
    localparam logic [1:0] OP_STAT = 2'd3;

    // kinds of a result word
    localparam logic [1:0] KIND_PUT_ACK = 2'd0;
    localparam logic [1:0] KIND_GET     = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_STAT    = 2'd3;

endpackage

FILE: sv/brf_ram.sv
// byte store: one write port, one read port with registered read data
module brf_ram #(
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/byte_ring_fifo_block_put_get.sv
// top level of the byte ring fifo with block puts and bounded gets
//
// input channel (i_valid / o_ready) carries one operation word: put byte,
// get block, clear indices or status query. output channel (o_valid /
// i_ready) returns result words from a single output register.
// a put word is acknowledged by one result in the cycle after it is taken;
// puts, status and clears are taken one per cycle while the receiver keeps up.
// a get of n bytes (n = min(requested, stored, MAX_GET)) issues reads of the
// byte store one per cycle while the receiver keeps up, as the store has a
// single read port: each byte passes the read data register of the store, then
// the output register, and the input is held until the last byte is loaded there.
// an empty get gives one result of kind empty in the cycle after it is taken.
// a clear word produces no result. writing i_cfg_wdata sets the ring size
// (2^size_log2, at least 2 and clamped to the memory depth) and clears both indices.
// reset clears indices, open put block and output valid; size_log2 returns
// to 8. the store contents are not cleared.
// when the receiver stalls the output register holds its word and the input
// side stops as soon as the next result has nowhere to go.
module byte_ring_fifo_block_put_get #(
    parameter int DEPTH   = brf_pkg::DEPTH_DEF,
    parameter int MAX_GET = brf_pkg::MAX_GET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_operation,
    input  logic       i_first_of_block,
    input  logic [8:0] i_block_length,
    input  logic [7:0] i_data_in,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic       o_accepted,
    output logic [7:0] o_data_out,
    output logic       o_last,
    output logic [8:0] o_stored_count,
    output logic [8:0] o_free_count
);

    // address, free-running index, compare and get count widths
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = AW + 1;
    localparam int CW = (IW > 9) ? IW : 9;
    localparam int TW = $clog2(MAX_GET + 1);

    typedef enum logic {ST_IDLE, ST_GET} t_state;

    t_state r_state, n_state;

    logic [3:0]    r_size_log2, n_size_log2;
    logic [IW-1:0] r_wi, n_wi;        // write index
    logic [IW-1:0] r_ri, n_ri;        // read index
    logic [IW-1:0] r_ptr, n_ptr;      // next read address during a get
    logic [TW-1:0] r_cnt, n_cnt;      // bytes of the get still to emit
    logic [8:0]    r_left, n_left;    // bytes of the open put block
    logic          r_adm, n_adm;      // open put block admitted
    logic          r_ov, n_ov;        // output register full

    // output payload
    logic [1:0] r_kind, n_kind;
    logic       r_acc, n_acc;
    logic [7:0] r_dout, n_dout;
    logic       r_last, n_last;
    logic [8:0] r_st, r_fr;
    logic       ld_out;

    // ring geometry
    logic [4:0]    lg_eff;
    logic [IW-1:0] size;
    logic [AW-1:0] mask;
    logic [IW-1:0] stored;
    logic [IW-1:0] free_sp;

    // memory ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free, in_acc;
    logic [CW-1:0] len_c, have_c, take_c, max_c;
    logic [TW-1:0] take;
    logic          p_adm, p_store;
    logic [8:0]    p_left;

    // counts after the step
    logic [IW-1:0] cnt_st, cnt_fr;
    logic [CW-1:0] cnt_st_w, cnt_fr_w;

    // get run start and final byte, for the checks below
    logic          get_go, get_done;

    always_comb begin
        if (r_size_log2 == 4'd0) begin
            lg_eff = 5'd1;
        end else if ({1'b0, r_size_log2} > 5'(AW)) begin
            lg_eff = 5'(AW);
        end else begin
            lg_eff = {1'b0, r_size_log2};
        end
    end

    assign size    = IW'(1) << lg_eff;
    assign mask    = AW'(size - IW'(1));
    assign stored  = r_wi - r_ri;
    assign free_sp = size - stored;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc   = i_valid && o_ready;

    // get length: min of request, fill and cap
    always_comb begin
        len_c  = CW'(i_block_length);
        have_c = CW'(stored);
        max_c  = CW'(MAX_GET);
        take_c = len_c;
        if (take_c > have_c) begin
            take_c = have_c;
        end
        if (take_c > max_c) begin
            take_c = max_c;
        end
    end
    assign take = TW'(take_c);

    // put admission on the first byte of a block
    always_comb begin
        if (i_first_of_block) begin
            p_adm  = (i_block_length != 9'd0) && (len_c <= CW'(free_sp));
            p_left = p_adm ? i_block_length : 9'd0;
        end else begin
            p_adm  = r_adm;
            p_left = r_left;
        end
        p_store = p_adm && (p_left != 9'd0) && (stored < size);
    end

    always_comb begin
        n_state     = r_state;
        n_size_log2 = r_size_log2;
        n_wi        = r_wi;
        n_ri        = r_ri;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_adm       = r_adm;
        n_ov        = r_ov && !i_ready;
        n_kind      = r_kind;
        n_acc       = r_acc;
        n_dout      = r_dout;
        n_last      = r_last;
        ld_out      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wi[AW-1:0] & mask;
        ram_re      = 1'b0;
        ram_raddr   = r_ri[AW-1:0] & mask;

        priority if (i_cfg_we) begin
            n_size_log2 = i_cfg_wdata;
            n_wi        = '0;
            n_ri        = '0;
            n_left      = 9'd0;
            n_adm       = 1'b0;
        end else if (in_acc) begin
            unique case (i_operation)
                brf_pkg::OP_PUT: begin
                    ram_we = p_store;
                    n_wi   = r_wi + IW'(p_store);
                    n_left = p_left - 9'(p_store);
                    n_adm  = p_adm && (n_left != 9'd0);
                    ld_out = 1'b1;
                    n_kind = brf_pkg::KIND_PUT_ACK;
                    n_acc  = p_store;
                    n_dout = 8'd0;
                    n_last = 1'b1;
                end
                brf_pkg::OP_GET: begin
                    if (take == TW'(0)) begin
                        ld_out = 1'b1;
                        n_kind = brf_pkg::KIND_EMPTY;
                        n_acc  = 1'b1;
                        n_dout = 8'd0;
                        n_last = 1'b1;
                    end else begin
                        // first read goes out now, indices jump to the end
                        ram_re  = 1'b1;
                        n_ptr   = r_ri + IW'(1);
                        n_ri    = r_ri + IW'(take);
                        n_cnt   = take;
                        n_state = ST_GET;
                    end
                end
                brf_pkg::OP_CLR: begin
                    n_wi   = '0;
                    n_ri   = '0;
                    n_left = 9'd0;
                    n_adm  = 1'b0;
                end
                brf_pkg::OP_STAT: begin
                    ld_out = 1'b1;
                    n_kind = brf_pkg::KIND_STAT;
                    n_acc  = 1'b1;
                    n_dout = 8'd0;
                    n_last = 1'b1;
                end
            endcase
        end else if ((r_state == ST_GET) && out_free) begin
            // read data of the last issued read moves to the output register
            ld_out = 1'b1;
            n_kind = brf_pkg::KIND_GET;
            n_acc  = 1'b1;
            n_dout = ram_rdata;
            n_last = (r_cnt == TW'(1));
            n_cnt  = r_cnt - TW'(1);
            if (r_cnt == TW'(1)) begin
                n_state = ST_IDLE;
            end else begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr[AW-1:0] & mask;
                n_ptr     = r_ptr + IW'(1);
            end
        end else begin
            // nothing taken and no get byte can move: everything holds
        end

        if (ld_out) begin
            n_ov = 1'b1;
        end
    end

    // counts reported with each result, taken after the whole step
    always_comb begin
        cnt_st = n_wi - n_ri;
        if (cnt_st > size) begin
            cnt_st = size;
        end
        cnt_fr   = size - cnt_st;
        cnt_st_w = CW'(cnt_st);
        cnt_fr_w = CW'(cnt_fr);
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_kind <= n_kind;
        r_acc  <= n_acc;
        r_dout <= n_dout;
        r_last <= n_last;
        if (ld_out) begin
            r_st <= cnt_st_w[8:0];
            r_fr <= cnt_fr_w[8:0];
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size_log2 <= brf_pkg::SIZE_LOG2_RST;
            r_wi        <= '0;
            r_ri        <= '0;
            r_left      <= 9'd0;
            r_adm       <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size_log2 <= n_size_log2;
            r_wi        <= n_wi;
            r_ri        <= n_ri;
            r_left      <= n_left;
            r_adm       <= n_adm;
            r_ov        <= n_ov;
        end
    end

    brf_ram #(
        .AW(AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_accepted     = r_acc;
    assign o_data_out     = r_dout;
    assign o_last         = r_last;
    assign o_stored_count = r_st;
    assign o_free_count   = r_fr;

    assign get_go   = in_acc && (i_operation == brf_pkg::OP_GET) && (take != TW'(0));
    assign get_done = (r_state == ST_GET) && out_free && (r_cnt == TW'(1));

`include "byte_ring_fifo_block_put_get_defines.svh"

    `BRF_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, stored <= size, "fill above ring size")
    `BRF_ASSERT_NOW(a_get_cnt, i_clk, i_rst_n, r_state == ST_GET, r_cnt != TW'(0), "empty get run")
    `BRF_ASSERT_NOW(a_adm_left, i_clk, i_rst_n, r_adm, r_left != 9'd0, "admitted with none left")
    `BRF_ASSERT_NXT(a_get_start, i_clk, i_rst_n, get_go, r_state == ST_GET, "get did not start")
    `BRF_ASSERT_NXT(a_get_end, i_clk, i_rst_n, get_done, (r_state == ST_IDLE) && o_last, "no last")

endmodule
